// ----- design/kwm_pkg.sv -----
// shared types and codes of the k-way merge unit
package kwm_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned INDEX_W = 3;
  localparam int unsigned STATUS_W = 2;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_TAKE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic take;
    logic idx_ok;
    logic [INDEX_W-1:0] list_index;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

endpackage

// ----- design/kwm_if.sv -----
// request and response channel interfaces of the k-way merge unit
interface kwm_req_if;
  import kwm_pkg::*;

  logic valid;
  logic ready;
  logic opcode;
  logic [INDEX_W-1:0] list_index;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output opcode, output list_index, output value, input ready);
  modport sink (input valid, input opcode, input list_index, input value, output ready);
endinterface

interface kwm_rsp_if;
  import kwm_pkg::*;

  logic valid;
  logic ready;
  logic [STATUS_W-1:0] status;
  logic signed [VALUE_W-1:0] value_out;
  logic [INDEX_W-1:0] source_list;

  modport source (output valid, output status, output value_out, output source_list,
                  input ready);
  modport sink (input valid, input status, input value_out, input source_list,
                output ready);
endinterface

// ----- design/kwm_front.sv -----
// front end: accepts request transactions, classifies them, queues commands
module kwm_front #(
  parameter int LISTS = 8
) (
  input  logic           clk,
  input  logic           rst,
  kwm_req_if.sink        req,
  output logic           q_valid,
  output kwm_pkg::cmd_t  q_cmd,
  input  logic           q_pop
);
  import kwm_pkg::*;

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  cmd_t       cmd_in;

  assign req.ready = (count != 2'd2);
  assign push = req.valid && req.ready;
  assign q_valid = (count != 2'd0);
  assign q_cmd = entries[rd_ptr];

  always_comb begin
    cmd_in.take = (req.opcode == OP_TAKE);
    cmd_in.idx_ok = (int'(req.list_index) < LISTS);
    cmd_in.list_index = req.list_index;
    cmd_in.value = req.value;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, q_pop})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- design/kwm_back.sv -----
// back end: per-sequence fifos in one store, head scan and result register
module kwm_back #(
  parameter int LISTS = 8,
  parameter int DEPTH = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  kwm_pkg::cmd_t  q_cmd,
  output logic           q_pop,
  kwm_rsp_if.source      rsp
);
  import kwm_pkg::*;

  localparam int LW = $clog2(LISTS);
  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(LISTS * DEPTH);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DRAIN, S_RESULT} state_t;

  state_t state;

  logic signed [VALUE_W-1:0] store [LISTS * DEPTH];
  logic signed [VALUE_W-1:0] mem_q;

  logic [PW-1:0] head [LISTS];
  logic [CW-1:0] fill [LISTS];

  logic [LW-1:0] scan_i;
  logic          pend;
  logic [LW-1:0] pend_list;
  logic          found;
  logic [LW-1:0] best;
  logic signed [VALUE_W-1:0] best_val;

  logic [STATUS_W-1:0]       r_status;
  logic signed [VALUE_W-1:0] r_value;
  logic [INDEX_W-1:0]        r_src;
  logic                      r_take;

  logic                      res_valid;
  logic [STATUS_W-1:0]       res_status;
  logic signed [VALUE_W-1:0] res_value;
  logic [INDEX_W-1:0]        res_src;

  logic [LW-1:0] sel;
  logic [PW-1:0] sel_head;
  logic [CW-1:0] sel_fill;
  logic [CW:0]   tail_sum;
  logic [PW-1:0] tail;
  logic [PW-1:0] head_next;
  logic [AW-1:0] base;
  logic [AW-1:0] mem_addr;
  logic          mem_we;
  logic          mem_re;
  logic          slot_free;

  logic                      upd;
  logic                      found_n;
  logic [LW-1:0]             best_n;
  logic signed [VALUE_W-1:0] val_n;

  always_comb begin
    case (state)
      S_IDLE: sel = LW'(q_cmd.list_index);
      S_SCAN: sel = scan_i;
      S_RESULT: sel = best;
      default: sel = best;
    endcase
  end

  assign sel_head = head[sel];
  assign sel_fill = fill[sel];
  assign tail_sum = (CW+1)'(sel_head) + (CW+1)'(sel_fill);
  assign tail = (tail_sum >= (CW+1)'(DEPTH)) ? PW'(tail_sum - (CW+1)'(DEPTH))
                                             : PW'(tail_sum);
  assign head_next = (sel_head == PW'(DEPTH - 1)) ? '0 : sel_head + PW'(1);
  assign base = AW'(sel) * AW'(DEPTH);
  assign mem_addr = base + AW'((state == S_IDLE) ? tail : sel_head);

  assign q_pop = (state == S_IDLE) && q_valid;
  assign mem_we = q_pop && !q_cmd.take && q_cmd.idx_ok && (sel_fill != CW'(DEPTH));
  assign mem_re = (state == S_SCAN) && (sel_fill != '0);
  assign slot_free = !res_valid || rsp.ready;

  assign upd = pend && (!found || (mem_q <= best_val));
  assign found_n = found || upd;
  assign best_n = upd ? pend_list : best;
  assign val_n = upd ? mem_q : best_val;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_addr] <= q_cmd.value;
    end
    if (mem_re) begin
      mem_q <= store[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      scan_i <= '0;
      pend <= 1'b0;
      pend_list <= '0;
      found <= 1'b0;
      best <= '0;
      r_take <= 1'b0;
      res_valid <= 1'b0;
      for (int i = 0; i < LISTS; i++) begin
        head[i] <= '0;
        fill[i] <= '0;
      end
    end else begin
      if (state == S_RESULT && slot_free) begin
        res_valid <= 1'b1;
      end else if (rsp.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            r_take <= 1'b0;
            r_value <= '0;
            r_src <= '0;
            if (q_cmd.take) begin
              found <= 1'b0;
              pend <= 1'b0;
              scan_i <= '0;
              state <= S_SCAN;
            end else begin
              if (mem_we) begin
                fill[sel] <= sel_fill + CW'(1);
                r_status <= ST_OK;
              end else begin
                r_status <= ST_FULL;
              end
              state <= S_RESULT;
            end
          end
        end
        S_SCAN: begin
          found <= found_n;
          best <= best_n;
          best_val <= val_n;
          pend <= mem_re;
          pend_list <= scan_i;
          if (scan_i == LW'(LISTS - 1)) begin
            scan_i <= '0;
            state <= S_DRAIN;
          end else begin
            scan_i <= scan_i + LW'(1);
          end
        end
        S_DRAIN: begin
          pend <= 1'b0;
          found <= 1'b0;
          best <= best_n;
          r_take <= found_n;
          r_status <= found_n ? ST_OK : ST_EMPTY;
          r_value <= found_n ? val_n : '0;
          r_src <= found_n ? INDEX_W'(best_n) : '0;
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (slot_free) begin
            res_status <= r_status;
            res_value <= r_value;
            res_src <= r_src;
            if (r_take) begin
              head[sel] <= head_next;
              fill[sel] <= sel_fill - CW'(1);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid = res_valid;
  assign rsp.status = res_status;
  assign rsp.value_out = res_value;
  assign rsp.source_list = res_src;

endmodule

// ----- design/k_way_sorted_merge_unit.sv -----
// top level of the k-way merge unit
// Holds LISTS sequences, each a circular fifo of DEPTH signed 32-bit words in one
// shared store. A request transaction either appends a value to a sequence (status 1
// if the sequence is full or its number is LISTS or more) or takes the smallest head
// over all non-empty sequences, ties going to the higher sequence number (status 2
// if all are empty). Every request gives exactly one response transaction, in order.
// A take scans the sequence heads, one head per cycle, through the single store read
// port and one comparator. A two-entry command queue lets requests be accepted while
// the back end works or a response waits.
module k_way_sorted_merge_unit #(
  parameter int LISTS = 8,
  parameter int DEPTH = 256
) (
  input logic        clk,
  input logic        rst,
  kwm_req_if.sink    req,
  kwm_rsp_if.source  rsp
);
  import kwm_pkg::*;

  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  kwm_front #(
    .LISTS (LISTS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop)
  );

  kwm_back #(
    .LISTS (LISTS),
    .DEPTH (DEPTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop),
    .rsp     (rsp)
  );

endmodule

// ----- tb/kwm_merge_checker.sv -----
// checker: watches both channels, predicts each response of the merge unit and compares
module kwm_merge_checker #(
  parameter int LISTS = 8,
  parameter int DEPTH = 256
) (
  input  logic clk,
  input  logic rst,
  kwm_req_if   req,
  kwm_rsp_if   rsp,
  output int   fail_count,
  output int   open_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import kwm_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] value_out;
    logic [INDEX_W-1:0]        source_list;
  } merge_result_t;

  logic signed [VALUE_W-1:0] list_words [LISTS][DEPTH];
  int unsigned list_head [LISTS];
  int unsigned list_fill [LISTS];
  merge_result_t expected_q [$];

  function automatic merge_result_t merge_predict(input logic op,
                                                  input logic [INDEX_W-1:0] idx,
                                                  input logic signed [VALUE_W-1:0] val);
    merge_result_t res;
    int best;
    logic signed [VALUE_W-1:0] best_word;
    res = '0;
    best = -1;
    best_word = '0;
    if (op == OP_APPEND) begin
      if (idx >= LISTS || list_fill[idx] >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        list_words[idx][(list_head[idx] + list_fill[idx]) % DEPTH] = val;
        list_fill[idx]++;
        res.status = ST_OK;
      end
    end else begin
      // ties go to the higher list number
      for (int i = 0; i < LISTS; i++) begin
        if (list_fill[i] != 0 && (best < 0 || list_words[i][list_head[i]] <= best_word)) begin
          best = i;
          best_word = list_words[i][list_head[i]];
        end
      end
      if (best < 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.status = ST_OK;
        res.value_out = best_word;
        res.source_list = best[INDEX_W-1:0];
        list_head[best] = (list_head[best] + 1) % DEPTH;
        list_fill[best]--;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    merge_result_t got;
    merge_result_t want;
    merge_result_t pred;
    if (rst) begin
      foreach (list_head[i]) begin
        list_head[i] = 0;
        list_fill[i] = 0;
      end
      expected_q.delete();
    end else begin
      if (req.valid && req.ready) begin
        pred = merge_predict(req.opcode, req.list_index, req.value);
        expected_q = {expected_q, pred};
      end
      if (rsp.valid && rsp.ready) begin
        got.status = rsp.status;
        got.value_out = rsp.value_out;
        got.source_list = rsp.source_list;
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: unexpected response transaction: status %0d value %0d list %0d",
                     $realtime, got.status, got.value_out, got.source_list);
          end
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                       $realtime, want.status, want.value_out, want.source_list,
                       got.status, got.value_out, got.source_list);
            end
          end
        end
      end
    end
    open_count = expected_q.size();
  end

endmodule

// ----- tb/k_way_sorted_merge_unit_test.sv -----
// testbench top of the k-way merge unit: clock, reset, stimulus and verdict
module k_way_sorted_merge_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import kwm_pkg::*;

  localparam int LISTS = 8;
  localparam int DEPTH = 256;
  localparam int TOTAL_ITEMS = 1400;
  localparam int LONG_HOLD = 300;
  localparam int IDLE_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int fail_count;
  int open_count;
  int items_sent;
  int idle_cycles;
  bit burst;
  bit long_hold_req;
  bit flooded;
  logic signed [VALUE_W-1:0] last_word [LISTS];

  kwm_req_if req ();
  kwm_rsp_if rsp ();

  always #5 clk = ~clk;

  k_way_sorted_merge_unit #(.LISTS(LISTS), .DEPTH(DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  kwm_merge_checker #(.LISTS(LISTS), .DEPTH(DEPTH)) merge_check (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .fail_count (fail_count),
    .open_count (open_count)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  // next word of an ascending sequence, saturating at the top of the range
  function automatic logic signed [VALUE_W-1:0] next_word(input int lst, input int step_max);
    longint v;
    v = longint'(last_word[lst]) + longint'($urandom_range(0, step_max));
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    last_word[lst] = v[VALUE_W-1:0];
    return last_word[lst];
  endfunction

  task automatic send_item(input logic op, input logic [INDEX_W-1:0] idx,
                           input logic signed [VALUE_W-1:0] val);
    int gap;
    gap = burst ? 0 : pick_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.opcode <= op;
    req.list_index <= idx;
    req.value <= val;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic append_word(input int lst, input logic signed [VALUE_W-1:0] w);
    send_item(OP_APPEND, INDEX_W'(lst), w);
  endtask

  task automatic take_head();
    send_item(OP_TAKE, INDEX_W'($urandom()), $urandom());
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
  endtask

  // ascending sequences on a random subset of lists, interleaved with takes
  task automatic merge_round();
    int total;
    int lst;
    int step_max;
    int mode;
    bit [LISTS-1:0] used;
    mode = $urandom_range(0, 2);
    step_max = (mode == 0) ? 2 : ((mode == 1) ? 1000 : 32'h0fff_ffff);
    used = LISTS'($urandom());
    if (used == '0) used[$urandom_range(0, LISTS-1)] = 1'b1;
    for (int i = 0; i < LISTS; i++) begin
      last_word[i] = (mode == 0) ? $urandom_range(0, 6) - 3 : $urandom();
    end
    total = $urandom_range(1, 16);
    for (int k = 0; k < total; k++) begin
      do lst = $urandom_range(0, LISTS-1); while (!used[lst]);
      append_word(lst, next_word(lst, step_max));
      if ($urandom_range(0, 3) == 0) take_head();
    end
    repeat (total / 2 + $urandom_range(0, total)) take_head();
  endtask

  task automatic noise_round();
    repeat ($urandom_range(5, 20)) begin
      send_item(1'($urandom_range(0, 1)), INDEX_W'($urandom()), $urandom());
    end
  endtask

  // fill one list past full while responses are held off, then drain everything
  task automatic flood_round();
    int lst;
    lst = $urandom_range(0, LISTS-1);
    last_word[lst] = -32'sd100000;
    burst = 1'b1;
    long_hold_req = 1'b1;
    repeat (DEPTH + 4) append_word(lst, next_word(lst, 100000));
    wait_drained();
    burst = 1'b0;
    repeat (DEPTH + 8) take_head();
  endtask

  initial begin
    int r;
    req.valid <= 1'b0;
    req.opcode <= OP_APPEND;
    req.list_index <= '0;
    req.value <= '0;
    burst = 1'b0;
    long_hold_req = 1'b0;
    flooded = 1'b0;
    items_sent = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // extremes, ties and the empty case
    take_head();
    append_word(0, 32'sh8000_0000);
    append_word(1, 32'sd5);
    append_word(2, 32'sd5);
    append_word(3, 32'sd0);
    append_word(4, -32'sd1);
    append_word(5, 32'sd5);
    append_word(6, 32'sh7fff_ffff);
    append_word(7, 32'sh7fff_ffff);
    repeat (LISTS + 1) take_head();
    wait_drained();

    while (items_sent < TOTAL_ITEMS) begin
      if (!flooded && items_sent > 400) begin
        flood_round();
        flooded = 1'b1;
      end else begin
        burst = ($urandom_range(0, 4) == 0);
        r = $urandom_range(0, 9);
        if (r < 7) begin
          merge_round();
        end else if (r < 9) begin
          noise_round();
        end else begin
          wait_drained();
        end
      end
    end
    wait_drained();
    repeat (LISTS * 4) @(posedge clk);
    if (fail_count == 0 && open_count == 0) begin
      $display("PASS k_way_sorted_merge_unit");
    end else begin
      $display("FAIL k_way_sorted_merge_unit");
    end
    $finish;
  end

  // response side back-pressure
  initial begin
    int stall_left;
    int run_left;
    stall_left = 0;
    run_left = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = LONG_HOLD;
        run_left = 1;
      end
      if (stall_left == 0 && run_left == 0) begin
        if ($urandom_range(0, 9) == 0) begin
          run_left = $urandom_range(30, 120);
        end else begin
          stall_left = pick_gap();
          run_left = $urandom_range(1, 10);
        end
      end
      if (stall_left > 0) begin
        rsp.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp.ready <= 1'b1;
        run_left--;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL k_way_sorted_merge_unit");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
